### rtl/pbs_pkg.sv
// Package for the projection bands stream core: widths, constants, FSM state type, command and status structs.
// No dependencies.
`default_nettype none
package pbs_pkg;
   localparam int MAX_WINDOW  = 64;
   localparam int PRICE_BITS  = 32;
   localparam int IDX_BITS    = $clog2(MAX_WINDOW);
   localparam int WIN_BITS    = 7;
   localparam int NUM_BITS    = 50;
   localparam int DEN_BITS    = 18;
   localparam int QUO_BITS    = 54;
   localparam int ACC_BITS    = 64;
   localparam logic [WIN_BITS-1:0] WINDOW_RESET = 7'd20;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_LOAD,
      ST_DIVIDE,
      ST_SCAN,
      ST_FINISH,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic start_update;
      logic start_divide;
      logic div_step;
      logic start_scan;
      logic scan_step;
      logic finish;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic window_full;
      logic div_last;
      logic scan_last;
      logic out_busy;
   } status_type;
endpackage
`default_nettype wire

### rtl/pbs_stream_if.sv
// Valid/ready stream interface carrying a generic payload.
// Depends on nothing.
`default_nettype none
interface pbs_stream_if #(parameter int WIDTH = 96) (input wire logic clock);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

### rtl/pbs_control.sv
// Controller state machine for the projection bands core.
// Depends on pbs_pkg.
`default_nettype none
module pbs_control (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_fire,
   input  wire pbs_pkg::status_type status,
   output pbs_pkg::cmd_type        cmd,
   output logic                    busy
);
   import pbs_pkg::*;
   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_fire) state_in = ST_UPDATE;
         ST_UPDATE: state_in = status.window_full ? ST_LOAD : ST_IDLE;
         ST_LOAD:   state_in = ST_DIVIDE;
         ST_DIVIDE: if (status.div_last) state_in = ST_SCAN;
         ST_SCAN:   if (status.scan_last) state_in = ST_FINISH;
         ST_FINISH: state_in = ST_OUTPUT;
         ST_OUTPUT: if (!status.out_busy) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      busy = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            cmd.start_update = req_fire;
         end
         ST_UPDATE: cmd = '0;
         ST_LOAD:   cmd.start_divide = 1'b1;
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cmd.start_scan = status.div_last;
         end
         ST_SCAN:   cmd.scan_step = 1'b1;
         ST_FINISH: cmd.finish = 1'b1;
         ST_OUTPUT: cmd.load_out = !status.out_busy;
         default:   busy = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   property p_no_accept_busy;
      @(posedge clock) disable iff (reset) (state_ff != ST_IDLE) |-> !cmd.start_update;
   endproperty
   a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept while busy");
   a_scan_after_div: assert property (@(posedge clock) disable iff (reset)
      cmd.start_scan |=> state_ff == ST_SCAN) else $error("scan not entered");
   a_out_done: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> state_ff == ST_IDLE) else $error("output not retired");
endmodule
`default_nettype wire

### rtl/pbs_datapath.sv
// Datapath: rings, running sums, serial slope divider, band scan, output register.
// Depends on pbs_pkg.
`default_nettype none
module pbs_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [pbs_pkg::WIN_BITS-1:0]  csr_wdata,
   input  wire logic [pbs_pkg::PRICE_BITS-1:0] in_high,
   input  wire logic [pbs_pkg::PRICE_BITS-1:0] in_low,
   input  wire logic [pbs_pkg::PRICE_BITS-1:0] in_close,
   input  wire pbs_pkg::cmd_type              cmd,
   output pbs_pkg::status_type                status,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output logic [pbs_pkg::PRICE_BITS-1:0]     out_upper,
   output logic [pbs_pkg::PRICE_BITS-1:0]     out_lower
);
   import pbs_pkg::*;
   localparam int PB = PRICE_BITS;
   localparam int CS_BITS = 38;
   localparam int WS_BITS = 45;
   localparam int CNT_BITS = $clog2(NUM_BITS + 16 + 1);

   logic [PB-1:0] high_mem [MAX_WINDOW];
   logic [PB-1:0] low_mem  [MAX_WINDOW];
   logic [PB-1:0] close_mem [MAX_WINDOW];

   logic [WIN_BITS-1:0] window_ff;
   logic [WIN_BITS-1:0] seen_ff;
   logic [IDX_BITS-1:0] pos_ff, newest_ff;
   logic signed [CS_BITS-1:0] csum_ff;
   logic signed [WS_BITS-1:0] wsum_ff;
   logic signed [PB-1:0] h_ff, l_ff, c_ff, old_ff;
   logic [WIN_BITS-1:0] p;
   logic full_now;
   logic upd_ff;

   // effective window
   always_comb begin
      if (window_ff == '0) p = 7'd1;
      else if (window_ff > WIN_BITS'(MAX_WINDOW)) p = WIN_BITS'(MAX_WINDOW);
      else p = window_ff;
   end

   // capture bar, read the leaving close
   always_ff @(posedge clock) begin
      if (cmd.start_update) begin
         h_ff <= in_high;
         l_ff <= in_low;
         c_ff <= in_close;
         old_ff <= close_mem[pos_ff - IDX_BITS'(p)];
         high_mem[pos_ff] <= in_high;
         low_mem[pos_ff] <= in_low;
         close_mem[pos_ff] <= in_close;
      end
   end

   // running sums and counters
   assign full_now = (seen_ff >= p);
   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         if (reset) window_ff <= WINDOW_RESET;
         else window_ff <= csr_wdata;
         seen_ff <= '0;
         pos_ff <= '0;
         csum_ff <= '0;
         wsum_ff <= '0;
      end else if (cmd.start_update) begin
         pos_ff <= pos_ff + 1'b1;
         newest_ff <= pos_ff;
      end
      if (!reset && !csr_we && upd_ff) begin
         if (!full_now) begin
            wsum_ff <= wsum_ff + WS_BITS'($signed({1'b0, seen_ff}) + 1) * WS_BITS'(c_ff);
            csum_ff <= csum_ff + CS_BITS'(c_ff);
            seen_ff <= seen_ff + 1'b1;
         end else begin
            wsum_ff <= wsum_ff + WS_BITS'($signed({1'b0, p})) * WS_BITS'(c_ff)
                       - WS_BITS'(csum_ff);
            csum_ff <= csum_ff + CS_BITS'(c_ff) - CS_BITS'(old_ff);
         end
      end
   end
   always_ff @(posedge clock) begin
      if (reset) upd_ff <= 1'b0;
      else upd_ff <= cmd.start_update;
   end
   // window full after this update (sums settle with the update cycle)
   assign status.window_full = (seen_ff >= p) || (seen_ff + 1'b1 >= p);

   // slope: numerator and denominator, restoring divider one bit a cycle
   logic signed [NUM_BITS-1:0] num;
   logic [DEN_BITS-1:0] den;
   logic [NUM_BITS-1:0] mag;
   logic [NUM_BITS+16-1:0] dvd_ff;
   logic [DEN_BITS:0] rem_ff;
   logic [CNT_BITS-1:0] dcnt_ff;
   logic neg_ff, p1_ff;
   logic [DEN_BITS:0] trial;
   logic [DEN_BITS-1:0] den_ff;
   // new sums are visible at start_divide, in the cycle after the update
   always_comb begin
      num = NUM_BITS'(12) * NUM_BITS'(wsum_ff)
            - NUM_BITS'(6) * NUM_BITS'({1'b0, p} + 8'd1) * NUM_BITS'(csum_ff);
      den = DEN_BITS'(p) * (DEN_BITS'(p) * DEN_BITS'(p) - 1'b1);
      mag = num[NUM_BITS-1] ? NUM_BITS'(-num) : NUM_BITS'(num);
   end
   assign trial = {rem_ff[DEN_BITS-1:0], dvd_ff[NUM_BITS+15]} - {1'b0, den_ff};
   always_ff @(posedge clock) begin
      if (cmd.start_divide) begin
         dvd_ff <= {mag, 16'd0};
         rem_ff <= '0;
         den_ff <= den;
         neg_ff <= num[NUM_BITS-1];
         p1_ff <= (p < 7'd2);
         dcnt_ff <= CNT_BITS'(NUM_BITS + 16 - 1);
      end else if (cmd.div_step) begin
         if (!trial[DEN_BITS]) begin
            rem_ff <= trial;
            dvd_ff <= {dvd_ff[NUM_BITS+14:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[DEN_BITS-1:0], dvd_ff[NUM_BITS+15]};
            dvd_ff <= {dvd_ff[NUM_BITS+14:0], 1'b0};
         end
         dcnt_ff <= dcnt_ff - 1'b1;
      end
   end
   assign status.div_last = (dcnt_ff == '0);
   // after the last step, the fire of start_scan sees quotient after this step
   logic [NUM_BITS+15:0] quo_fin;
   assign quo_fin = {dvd_ff[NUM_BITS+14:0], !trial[DEN_BITS]};

   localparam logic signed [ACC_BITS-1:0] SLOPE_LIM = ACC_BITS'(64'sd1 <<< 52);
   logic signed [ACC_BITS-1:0] slope_ff, jb_ff;
   logic signed [ACC_BITS-1:0] slope_mag;
   always_comb begin
      if (quo_fin > (NUM_BITS+16)'(SLOPE_LIM)) slope_mag = SLOPE_LIM;
      else slope_mag = ACC_BITS'(quo_fin);
   end

   // band scan, one entry per cycle
   logic signed [ACC_BITS-1:0] hi_ff, lo_ff;
   logic [WIN_BITS-1:0] j_ff;
   logic [IDX_BITS-1:0] ridx_ff;
   logic signed [PB-1:0] rh_ff, rl_ff;
   logic rvalid_ff;
   logic signed [ACC_BITS-1:0] jb_use_ff, hc, lc;
   always_comb begin
      hc = (ACC_BITS'(rh_ff) <<< 16) + jb_use_ff;
      lc = (ACC_BITS'(rl_ff) <<< 16) + jb_use_ff;
   end
   always_ff @(posedge clock) begin
      if (cmd.start_scan) begin
         slope_ff <= p1_ff ? '0 : (neg_ff ? -slope_mag : slope_mag);
         jb_ff <= '0;
         j_ff <= '0;
         ridx_ff <= newest_ff;
         rvalid_ff <= 1'b0;
         hi_ff <= {1'b1, {(ACC_BITS-1){1'b0}}};
         lo_ff <= {1'b0, {(ACC_BITS-1){1'b1}}};
      end else if (cmd.scan_step) begin
         rh_ff <= high_mem[ridx_ff];
         rl_ff <= low_mem[ridx_ff];
         jb_use_ff <= jb_ff;
         rvalid_ff <= (j_ff < p);
         ridx_ff <= ridx_ff - 1'b1;
         jb_ff <= jb_ff + slope_ff;
         j_ff <= j_ff + 1'b1;
         if (rvalid_ff) begin
            if (hc > hi_ff) hi_ff <= hc;
            if (lc < lo_ff) lo_ff <= lc;
         end
      end else if (cmd.finish && rvalid_ff) begin
         if (hc > hi_ff) hi_ff <= hc;
         if (lc < lo_ff) lo_ff <= lc;
      end
   end
   assign status.scan_last = (j_ff == p);

   // truncate toward zero and saturate
   function automatic logic [PB-1:0] to_out(input logic signed [ACC_BITS-1:0] v);
      logic signed [ACC_BITS-1:0] t;
      t = (v < 0) ? -((-v) >>> 16) : (v >>> 16);
      if (t > ACC_BITS'(32'sh7fffffff)) return 32'h7fffffff;
      if (t < -ACC_BITS'(33'sh80000000)) return 32'h80000000;
      return t[PB-1:0];
   endfunction

   // output register
   always_ff @(posedge clock) begin
      if (reset) out_valid <= 1'b0;
      else if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (cmd.load_out) begin
         out_upper <= to_out(hi_ff);
         out_lower <= to_out(lo_ff);
      end
   end
   assign status.out_busy = out_valid && !out_ready;

   a_div_len: assert property (@(posedge clock) disable iff (reset)
      cmd.start_divide |=> dcnt_ff == CNT_BITS'(NUM_BITS + 15)) else $error("divider load");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready && !cmd.load_out |=> $stable(out_upper))
      else $error("result changed");
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step |-> j_ff <= p) else $error("scan overrun");
endmodule
`default_nettype wire

### rtl/projection_bands_stream_core.sv
// Top level of the projection bands stream core.
// Depends on pbs_pkg, pbs_stream_if, pbs_control, pbs_datapath.
//
// Usage: bars (high, low, close, Q16.16) arrive on the req channel, payload
// {bar_close, bar_low, bar_high} with bar_high in the low 32 bits. Once the
// window is full each bar yields one rsp transaction {lower_band, upper_band},
// upper_band in the low 32 bits. csr_we/csr_wdata write the window length,
// which restarts the stream; write it only while idle.
// A warm-up bar frees req_ready once its update step is done. A result bar
// raises rsp_valid after an update step, a divider load, the bit-serial slope
// division, the scan of the stored highs and lows through the ring memory
// port, and the output load. The next bar can be accepted in the cycle after
// the output load. One bar is worked on at a time; req_ready is low meanwhile.
// Reset sets the window to 20 and empties the stream; no clearing pass.
// A stalled receiver holds the result register and the core waits for it.
`default_nettype none
module projection_bands_stream_core (
   input  wire logic      clock,
   input  wire logic      reset,
   pbs_stream_if.sink     req,
   pbs_stream_if.source   rsp,
   input  wire logic      csr_we,
   input  wire logic [pbs_pkg::WIN_BITS-1:0] csr_wdata
);
   import pbs_pkg::*;
   cmd_type cmd;
   status_type status;
   logic busy;
   logic req_fire;

   assign req.ready = !busy;
   assign req_fire = req.valid && !busy;

   pbs_control u_ctrl (
      .clock(clock), .reset(reset), .req_fire(req_fire),
      .status(status), .cmd(cmd), .busy(busy)
   );

   pbs_datapath u_dp (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .in_high(req.payload[31:0]), .in_low(req.payload[63:32]),
      .in_close(req.payload[95:64]), .cmd(cmd), .status(status),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .out_upper(rsp.payload[31:0]), .out_lower(rsp.payload[63:32])
   );
endmodule
`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for projection_bands_stream_core: random bars, window rewrites.
// Depends on pbs_pkg, pbs_stream_if and the core RTL.
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import pbs_pkg::*;

   typedef struct packed {
      logic signed [31:0] bar_close;
      logic signed [31:0] bar_low;
      logic signed [31:0] bar_high;
   } bar_type;

   typedef struct packed {
      logic signed [31:0] lower_band;
      logic signed [31:0] upper_band;
   } band_type;

   localparam int IDLE_LIMIT = 20000;

   logic clock;
   logic reset;
   logic csr_we;
   logic [WIN_BITS-1:0] csr_wdata;

   pbs_stream_if #(.WIDTH(96)) req_if (.clock(clock));
   pbs_stream_if #(.WIDTH(64)) rsp_if (.clock(clock));

   projection_bands_stream_core DUT (
      .clock(clock), .reset(reset), .req(req_if.sink), .rsp(rsp_if.source),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   // Predictor state
   logic signed [31:0] hist_high [MAX_WINDOW];
   logic signed [31:0] hist_low [MAX_WINDOW];
   logic signed [31:0] hist_close [MAX_WINDOW];
   longint sum_close, sum_weighted;
   int unsigned fill_count, write_slot;
   logic [WIN_BITS-1:0] window_reg;

   bar_type pending_bars[$];
   band_type band_queue[$];
   int mismatches, results_seen, bars_sent, idle_cycles;
   bit driver_hold;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void restart_stream();
      sum_close = 0;
      sum_weighted = 0;
      fill_count = 0;
      write_slot = 0;
   endfunction

   function automatic int unsigned active_window();
      if (window_reg < 1) return 1;
      if (window_reg > MAX_WINDOW) return MAX_WINDOW;
      return window_reg;
   endfunction

   function automatic longint regression_slope(int unsigned p);
      longint num, den, quo, rem, res;
      bit neg;
      if (p < 2) return 0;
      num = 12 * sum_weighted - 6 * longint'(p + 1) * sum_close;
      den = longint'(p) * (longint'(p) * p - 1);
      neg = num < 0;
      if (neg) num = -num;
      quo = num / den;
      rem = num % den;
      if (quo >= (longint'(1) << 37)) res = longint'(1) << 52;
      else begin
         res = quo * 65536 + (rem * 65536) / den;
         if (res > (longint'(1) << 52)) res = longint'(1) << 52;
      end
      return neg ? -res : res;
   endfunction

   function automatic logic signed [31:0] narrow_band(longint wide);
      longint v;
      v = wide / 65536;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
   endfunction

   // Advance the predictor by one bar; queue a band pair once the window is full
   function automatic void predict_bands(bar_type bar);
      int unsigned p, slot, j;
      longint slope, hi_best, lo_best, v;
      band_type bands;
      p = active_window();
      slot = write_slot % MAX_WINDOW;
      if (fill_count < p) begin
         sum_weighted += longint'(fill_count + 1) * bar.bar_close;
         sum_close += bar.bar_close;
         fill_count++;
      end else begin
         sum_weighted += longint'(p) * bar.bar_close - sum_close;
         sum_close += longint'(bar.bar_close)
                      - hist_close[(slot + MAX_WINDOW - p) % MAX_WINDOW];
      end
      hist_high[slot] = bar.bar_high;
      hist_low[slot] = bar.bar_low;
      hist_close[slot] = bar.bar_close;
      write_slot = (slot + 1) % MAX_WINDOW;
      if (fill_count < p) return;
      slope = regression_slope(p);
      hi_best = longint'(bar.bar_high) * 65536;
      lo_best = longint'(bar.bar_low) * 65536;
      for (j = 1; j < p; j++) begin
         v = longint'(hist_high[(slot + MAX_WINDOW - j) % MAX_WINDOW]) * 65536
             + longint'(j) * slope;
         if (v > hi_best) hi_best = v;
         v = longint'(hist_low[(slot + MAX_WINDOW - j) % MAX_WINDOW]) * 65536
             + longint'(j) * slope;
         if (v < lo_best) lo_best = v;
      end
      bands.upper_band = narrow_band(hi_best);
      bands.lower_band = narrow_band(lo_best);
      band_queue.push_back(bands);
   endfunction

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic signed [31:0] random_price();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         2: return $urandom;
         default: return 32'sd100 * 65536 + $signed($urandom_range(0, 2000000)) - 1000000;
      endcase
   endfunction

   // Note whether the presented transaction went through at the last rising edge
   bit req_taken;
   always @(posedge clock) req_taken <= req_if.valid && req_if.ready;

   // Driver: present queued bars at the falling edge with random gaps
   int drive_gap;
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         drive_gap = 0;
      end else if (req_if.valid && !req_taken) begin
         // hold the transaction
      end else if (drive_gap > 0) begin
         drive_gap--;
         req_if.valid <= 1'b0;
      end else if (pending_bars.size() > 0 && !driver_hold) begin
         req_if.payload <= pending_bars.pop_front();
         req_if.valid <= 1'b1;
         drive_gap = gap_length();
      end else begin
         req_if.valid <= 1'b0;
      end
   end

   // Receiver back-pressure
   int stall_left;
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
         stall_left = gap_length();
      end
   end

   // Monitor: predict on accepted bars, check accepted bands
   always @(posedge clock) begin
      band_type got, want;
      bit moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            predict_bands(bar_type'(req_if.payload));
            bars_sent <= bars_sent + 1;
            moved = 1'b1;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            moved = 1'b1;
            got = band_type'(rsp_if.payload);
            results_seen <= results_seen + 1;
            if (band_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected band pair %h", got);
            end else begin
               want = band_queue.pop_front();
               if (got.upper_band !== want.upper_band
                   || got.lower_band !== want.lower_band) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("band mismatch: upper exp %h got %h, lower exp %h got %h",
                              want.upper_band, got.upper_band,
                              want.lower_band, got.lower_band);
               end
            end
         end
         idle_cycles <= moved ? 0 : idle_cycles + 1;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout with %0d band pairs outstanding", band_queue.size());
         $display("projection_bands_stream_core regression: fail");
         $finish;
      end
   end

   task automatic drain();
      while (pending_bars.size() > 0 || req_if.valid || band_queue.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_window(logic [WIN_BITS-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      window_reg = value;
      restart_stream();
   endtask

   task automatic queue_random(int count);
      bar_type bar;
      repeat (count) begin
         bar.bar_high = random_price();
         bar.bar_low = random_price();
         bar.bar_close = random_price();
         pending_bars.push_back(bar);
      end
   endtask

   int phase;
   logic [WIN_BITS-1:0] window_choices [8] = '{7'd1, 7'd2, 7'd64, 7'd0, 7'd127, 7'd5, 7'd13, 7'd33};
   initial begin
      bar_type bar;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
      csr_we = 1'b0;
      csr_wdata = '0;
      mismatches = 0;
      results_seen = 0;
      bars_sent = 0;
      idle_cycles = 0;
      driver_hold = 0;
      window_reg = WINDOW_RESET;
      restart_stream();
      reset = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: reset window with extreme and flat prices
      for (int k = 0; k < 24; k++) begin
         case (k % 4)
            0: bar = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF};
            1: bar = '{32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000};
            2: bar = '{32'sh0, 32'sh0, 32'sh0};
            default: bar = '{32'shFFFFFFFF, 32'sh00010000, 32'sh55555555};
         endcase
         pending_bars.push_back(bar);
      end
      drain();

      // Random phases across window settings, pausing the sender in one of them
      for (phase = 0; phase < 16; phase++) begin
         write_window(window_choices[phase % 8]);
         if (phase == 3) begin
            queue_random(10);
            drain();
            driver_hold = 1;
            queue_random(10);
            repeat (5) @(posedge clock);
            driver_hold = 0;
         end
         queue_random(window_choices[phase % 8] > 40 ? 90 : 55);
         drain();
      end

      $display("covered %0d bars and %0d band pairs over 16 window settings",
               bars_sent, results_seen);
      if (mismatches == 0)
         $display("projection_bands_stream_core regression: pass");
      else
         $display("projection_bands_stream_core regression: fail");
      $finish;
   end
endmodule
`default_nettype wire
